[rtl/ndsf_pkg.sv]
// Shared types and constants for the near-duplicate string filter.
package ndsf_pkg;

	localparam int ENTRIES   = 16;
	localparam int MAX_CHARS = 32;

	localparam int CHAR_W = 8;
	localparam int THR_W  = 7;
	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int POS_W  = $clog2(MAX_CHARS);
	localparam int LEN_W  = $clog2(MAX_CHARS + 1);
	localparam int PROD_W = LEN_W + THR_W;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(20);
	localparam logic [THR_W-1:0] PERCENT   = THR_W'(100);

	typedef enum logic [1:0] {
		STAT_ADMITTED = 2'd0,
		STAT_SIMILAR  = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_TOO_LONG = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_CHAR,
		FSM_SCAN,
		FSM_DONE
	} fsm_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic              chr_en;
		logic [CHAR_W-1:0] chr;
		logic [POS_W-1:0]  pos;
		logic              clear;
		logic              commit;
		logic [LEN_W-1:0]  cand_len;
		logic [THR_W-1:0]  thr;
		logic [CNT_W-1:0]  entry_count;
	} cell_ctrl_t;

	// verdict token walking down the chain
	typedef struct packed {
		logic             active;
		logic             found;
		logic [IDX_W-1:0] index;
	} scan_t;

endpackage

[rtl/ndsf_cell.sv]
// One table entry: stored row, length, difference counter and one scan step.
module ndsf_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ndsf_pkg::cell_ctrl_t         ctrl,
	input  logic [ndsf_pkg::IDX_W-1:0]   my_idx,
	input  ndsf_pkg::scan_t              scan_in,
	output ndsf_pkg::scan_t              scan_out
);
	import ndsf_pkg::*;

	logic [CHAR_W-1:0] row_q [MAX_CHARS];
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  diff_q;
	scan_t             scan_q;

	logic              occupied;
	logic              wr_row;
	logic              mismatch;
	logic [LEN_W-1:0]  shorter;
	logic [PROD_W-1:0] lhs;
	logic [PROD_W-1:0] rhs;
	logic              fail;

	assign occupied = CNT_W'(my_idx) < ctrl.entry_count;
	assign wr_row   = CNT_W'(my_idx) == ctrl.entry_count;
	assign mismatch = (LEN_W'(ctrl.pos) < len_q) && (row_q[ctrl.pos] != ctrl.chr);

	assign shorter = (ctrl.cand_len < len_q) ? ctrl.cand_len : len_q;
	assign lhs     = PROD_W'(diff_q) * PROD_W'(PERCENT);
	assign rhs     = PROD_W'(ctrl.thr) * PROD_W'(shorter);
	assign fail    = occupied && !(lhs > rhs);

	always_ff @(posedge clk) begin
		if (ctrl.chr_en && wr_row) begin
			row_q[ctrl.pos] <= ctrl.chr;
		end
		if (ctrl.commit && wr_row) begin
			len_q <= ctrl.cand_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_q <= '0;
		end else if (ctrl.clear) begin
			diff_q <= '0;
		end else if (ctrl.chr_en && occupied && mismatch) begin
			diff_q <= LEN_W'(diff_q + 1'b1);
		end
	end

	// first failing entry along the chain wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q.active <= scan_in.active;
			scan_q.found  <= scan_in.found || (scan_in.active && fail);
			scan_q.index  <= scan_in.found ? scan_in.index : my_idx;
		end
	end

	assign scan_out = scan_q;

endmodule

[rtl/near_duplicate_string_filter_top.sv]
// Top level of the near-duplicate string filter: control, cell chain, output register.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata = char_code, s_tlast = last_char
//  m_*      out  m_tvalid/m_tready  m_tdata = status, stored_count, similar_index
//  cfg_*    in   cfg_we             cfg_wdata = threshold_percent
//
// Each accepted character within the row size goes to every cell at once; each occupied cell updates its own counter.
// After a final character the verdict walks the chain of ENTRIES cells, one per cycle,
// so input is held off in FSM_SCAN and FSM_DONE before the next character.
// The result sits in an output register; while it is stalled, the next verdict waits
// in FSM_DONE and input stays held off until the register is free.
// Reset clears the counters, table count and threshold (20); stored rows stay undefined.
module near_duplicate_string_filter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [1:0] status, [6:2] stored_count, [10:7] similar_index
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);
	import ndsf_pkg::*;

	fsm_t              state_q, state_d;
	logic [THR_W-1:0]  thr_q;
	logic [CNT_W-1:0]  entry_count_q;
	logic [LEN_W-1:0]  cand_len_q;
	logic              overlong_q;
	logic              start_q;
	logic              found_q;
	logic [IDX_W-1:0]  sidx_q;
	logic              m_tvalid_q;
	logic [15:0]       m_tdata_q;

	logic              accept;
	logic              fire;
	logic              room;
	status_t           status;
	logic [CNT_W-1:0]  count_next;
	logic [IDX_W-1:0]  idx_out;
	cell_ctrl_t        ctrl;
	scan_t             chain [ENTRIES+1];

	assign accept = s_tvalid && s_tready;
	assign room   = (cand_len_q != LEN_W'(MAX_CHARS));

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		fire     = 1'b0;
		unique case (state_q)
			FSM_CHAR: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tlast) begin
					state_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (chain[ENTRIES].active) begin
					state_d = FSM_DONE;
				end
			end
			FSM_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					fire    = 1'b1;
					state_d = FSM_CHAR;
				end
			end
			default: state_d = FSM_CHAR;
		endcase
	end

	always_comb begin
		if (overlong_q) begin
			status = STAT_TOO_LONG;
		end else if (entry_count_q == CNT_W'(ENTRIES)) begin
			status = STAT_FULL;
		end else if (found_q) begin
			status = STAT_SIMILAR;
		end else begin
			status = STAT_ADMITTED;
		end
	end

	assign count_next = (status == STAT_ADMITTED) ? CNT_W'(entry_count_q + 1'b1)
		: entry_count_q;
	assign idx_out    = (status == STAT_SIMILAR) ? sidx_q : '0;

	always_comb begin
		ctrl.chr_en      = accept && room;
		ctrl.chr         = s_tdata;
		ctrl.pos         = cand_len_q[POS_W-1:0];
		ctrl.clear       = fire;
		ctrl.commit      = fire && (status == STAT_ADMITTED);
		ctrl.cand_len    = cand_len_q;
		ctrl.thr         = thr_q;
		ctrl.entry_count = entry_count_q;
	end

	assign chain[0] = '{active: start_q, found: 1'b0, index: '0};

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		ndsf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.my_idx   (IDX_W'(g)),
			.scan_in  (chain[g]),
			.scan_out (chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_CHAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			cand_len_q    <= '0;
			overlong_q    <= 1'b0;
			start_q       <= 1'b0;
			found_q       <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			start_q <= accept && s_tlast;
			if (accept) begin
				if (room) begin
					cand_len_q <= LEN_W'(cand_len_q + 1'b1);
				end else begin
					overlong_q <= 1'b1;
				end
			end
			if (state_q == FSM_SCAN && chain[ENTRIES].active) begin
				found_q <= chain[ENTRIES].found;
			end
			if (fire) begin
				entry_count_q <= count_next;
				cand_len_q    <= '0;
				overlong_q    <= 1'b0;
				m_tvalid_q    <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_SCAN && chain[ENTRIES].active) begin
			sidx_q <= chain[ENTRIES].index;
		end
		if (fire) begin
			m_tdata_q <= {5'd0, 4'(idx_out), 5'(count_next), status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond table size");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		cand_len_q <= LEN_W'(MAX_CHARS))
		else $error("candidate length beyond row size");

	a_overlong_len: assert property (@(posedge clk) disable iff (!arst_n)
		overlong_q |-> (cand_len_q == LEN_W'(MAX_CHARS)))
		else $error("overlong flag set on a short candidate");

	a_token_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chain[ENTRIES].active |-> (state_q == FSM_SCAN))
		else $error("verdict token left the chain outside a scan");

	a_admit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && status == STAT_ADMITTED) |=>
		(entry_count_q == CNT_W'($past(entry_count_q) + 1'b1)))
		else $error("admitted request did not grow the table");

endmodule
